/* rtl/core/mfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message frame parser package
// Shared types, character codes and field widths of the frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLUMN_W = 31;
  localparam int unsigned LENGTH_W = 11;
  localparam int unsigned DCOUNT_W = 5;
  localparam int unsigned DIGIT_W  = 4;

  // Widths of the times-ten products before saturation or range check
  localparam int unsigned COL_PROD_W = COLUMN_W + 4;
  localparam int unsigned LEN_PROD_W = LENGTH_W + 4;

  localparam logic [COLUMN_W-1:0] COL_MAX = {COLUMN_W{1'b1}};

  localparam logic [BYTE_W-1:0] CH_QUERY    = 8'h3F;  // '?'
  localparam logic [BYTE_W-1:0] CH_RESPONSE = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] CH_UPDATE   = 8'h40;  // '@'
  localparam logic [BYTE_W-1:0] CH_PLAIN    = 8'h70;  // 'p'
  localparam logic [BYTE_W-1:0] CH_CIPHER   = 8'h63;  // 'c'
  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_COLUMN  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAIL   = 3'd4,
    PH_RESYNC  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MSG_QUERY    = 2'd0,
    MSG_RESPONSE = 2'd1,
    MSG_UPDATE   = 2'd2
  } msg_type_t;

  typedef enum logic [1:0] {
    ENC_PLAIN   = 2'd0,
    ENC_CIPHER  = 2'd1,
    ENC_INVALID = 2'd2
  } enc_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_TYPE  = 3'd1,
    ERR_BAD_DIGIT = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_LEN_BIG   = 3'd4,
    ERR_TRUNC     = 3'd5
  } err_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              buffer_end;
  } in_item_t;

  typedef struct packed {
    kind_t               out_kind;
    msg_type_t           msg_type;
    logic [COLUMN_W-1:0] column;
    enc_t                encryption;
    logic [LENGTH_W-1:0] payload_length;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    err_t                error_code;
  } result_t;

endpackage

/* rtl/core/mfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message frame parser channels
// Valid/ready channels for raw input bytes and for parser result items.
// ----------------------------------------------------------------------------
interface mfp_in_if import mfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              buffer_end;

  modport source (output valid, in_byte, buffer_end, input ready);
  modport sink (input valid, in_byte, buffer_end, output ready);
endinterface

interface mfp_out_if import mfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          out_kind;
  logic [1:0]          msg_type;
  logic [COLUMN_W-1:0] column;
  logic [1:0]          encryption;
  logic [LENGTH_W-1:0] payload_length;
  logic [BYTE_W-1:0]   data_byte;
  logic                last;
  logic [2:0]          error_code;

  modport source (output valid, out_kind, msg_type, column, encryption, payload_length,
                  data_byte, last, error_code, input ready);
  modport sink (input valid, out_kind, msg_type, column, encryption, payload_length,
                data_byte, last, error_code, output ready);
endinterface

/* rtl/core/mfp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser input register
// Captures one input item and holds it until the parser step takes it.
// ----------------------------------------------------------------------------
module mfp_in_stage import mfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mfp_in_if.sink    in_stream,
  input  logic      advance,
  output logic      item_valid,
  output in_item_t  item
);

  logic accept;

  assign in_stream.ready = !item_valid || advance;
  assign accept          = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.in_byte    <= in_stream.in_byte;
      item.buffer_end <= in_stream.buffer_end;
    end
  end

endmodule

/* rtl/core/mfp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser step
// Frame state and the combinational update that consumes one byte.
// ----------------------------------------------------------------------------
module mfp_step import mfp_pkg::*; #(
  parameter int unsigned MAX_DIGITS  = 20,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     advance,
  output logic     emit,
  output result_t  result
);

  phase_t              phase, phase_next;
  msg_type_t           frame_type, frame_type_next;
  logic [COLUMN_W-1:0] column_acc, column_acc_next;
  enc_t                enc_mark, enc_mark_next;
  logic [LENGTH_W-1:0] length_acc, length_acc_next;
  logic [DCOUNT_W-1:0] digit_count, digit_count_next;
  logic [LENGTH_W-1:0] bytes_left, bytes_left_next;

  logic [BYTE_W-1:0]     b;
  logic                  is_term;
  logic                  is_digit;
  logic                  is_newline;
  logic [DIGIT_W-1:0]    digit;
  logic [COL_PROD_W-1:0] col_prod;
  logic [LEN_PROD_W-1:0] len_prod;
  err_t                  err;
  kind_t                 kind;
  logic [BYTE_W-1:0]     data;
  logic                  last;
  logic                  frame_emit;

  assign b          = item.in_byte;
  assign is_newline = (b == CH_NEWLINE);
  assign is_term    = (b == CH_PLAIN) || (b == CH_CIPHER) || is_newline;
  assign is_digit   = b inside {[CH_ZERO:CH_NINE]};
  assign digit      = DIGIT_W'(b - CH_ZERO);

  // times ten as shift-and-add
  assign col_prod = ({4'b0, column_acc} << 3) + ({4'b0, column_acc} << 1)
                  + COL_PROD_W'(digit);
  assign len_prod = ({4'b0, length_acc} << 3) + ({4'b0, length_acc} << 1)
                  + LEN_PROD_W'(digit);

  always_comb begin
    phase_next       = phase;
    frame_type_next  = frame_type;
    column_acc_next  = column_acc;
    enc_mark_next    = enc_mark;
    length_acc_next  = length_acc;
    digit_count_next = digit_count;
    bytes_left_next  = bytes_left;
    err              = ERR_NONE;
    kind             = KIND_HEADER;
    data             = '0;
    last             = 1'b0;
    frame_emit       = 1'b0;

    case (phase)
      PH_COLUMN, PH_LENGTH: begin
        if (is_term) begin
          digit_count_next = '0;
          if (phase == PH_COLUMN) begin
            length_acc_next = '0;
            if (frame_type == MSG_QUERY) begin
              enc_mark_next = ENC_INVALID;
              phase_next    = PH_IDLE;
              last          = 1'b1;
              frame_emit    = 1'b1;
            end else begin
              enc_mark_next = (b == CH_PLAIN)  ? ENC_PLAIN :
                              (b == CH_CIPHER) ? ENC_CIPHER : ENC_INVALID;
              phase_next    = PH_LENGTH;
            end
          end else begin
            bytes_left_next = length_acc;
            frame_emit      = 1'b1;
            if (length_acc == '0) begin
              last       = 1'b1;
              phase_next = PH_TRAIL;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end else if (!is_digit) begin
          err = ERR_BAD_DIGIT;
        end else if (digit_count >= DCOUNT_W'(MAX_DIGITS)) begin
          err = ERR_TOO_LONG;
        end else begin
          digit_count_next = digit_count + DCOUNT_W'(1);
          if (phase == PH_COLUMN) begin
            column_acc_next = (col_prod > COL_PROD_W'(COL_MAX)) ? COL_MAX
                                                                : col_prod[COLUMN_W-1:0];
          end else if (len_prod > LEN_PROD_W'(MAX_PAYLOAD)) begin
            err = ERR_LEN_BIG;
          end else begin
            length_acc_next = len_prod[LENGTH_W-1:0];
          end
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LENGTH_W'(1);
        end
        kind       = KIND_PAYLOAD;
        data       = b;
        frame_emit = 1'b1;
        if (bytes_left_next == '0) begin
          last       = 1'b1;
          phase_next = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        phase_next = PH_IDLE;
      end
      PH_RESYNC: begin
        if (is_newline || item.buffer_end) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if ((b == CH_QUERY) || (b == CH_RESPONSE) || (b == CH_UPDATE)) begin
          frame_type_next  = (b == CH_QUERY)    ? MSG_QUERY :
                             (b == CH_RESPONSE) ? MSG_RESPONSE : MSG_UPDATE;
          column_acc_next  = '0;
          enc_mark_next    = ENC_PLAIN;
          length_acc_next  = '0;
          digit_count_next = '0;
          bytes_left_next  = '0;
          phase_next       = PH_COLUMN;
        end else begin
          err = ERR_BAD_TYPE;
        end
      end
    endcase

    // A byte error wins over truncation; truncation replaces a frame item.
    if (err != ERR_NONE) begin
      digit_count_next = '0;
      phase_next       = (is_newline || item.buffer_end) ? PH_IDLE : PH_RESYNC;
    end else if (item.buffer_end && (phase_next != PH_IDLE)) begin
      digit_count_next = '0;
      phase_next       = PH_IDLE;
      err              = ERR_TRUNC;
    end
  end

  always_comb begin
    emit = frame_emit || (err != ERR_NONE);
    if (err != ERR_NONE) begin
      result.out_kind       = KIND_ERROR;
      result.msg_type       = MSG_QUERY;
      result.column         = '0;
      result.encryption     = ENC_PLAIN;
      result.payload_length = '0;
      result.data_byte      = '0;
      result.last           = 1'b0;
      result.error_code     = err;
    end else begin
      result.out_kind       = kind;
      result.msg_type       = frame_type_next;
      result.column         = column_acc_next;
      result.encryption     = enc_mark_next;
      result.payload_length = length_acc_next;
      result.data_byte      = data;
      result.last           = last;
      result.error_code     = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      frame_type  <= MSG_QUERY;
      column_acc  <= '0;
      enc_mark    <= ENC_PLAIN;
      length_acc  <= '0;
      digit_count <= '0;
      bytes_left  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      frame_type  <= frame_type_next;
      column_acc  <= column_acc_next;
      enc_mark    <= enc_mark_next;
      length_acc  <= length_acc_next;
      digit_count <= digit_count_next;
      bytes_left  <= bytes_left_next;
    end
  end

  a_err_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    advance && emit && (result.out_kind == KIND_ERROR)
    |=> (phase == PH_IDLE) || (phase == PH_RESYNC))
    else $error("error item did not leave the frame");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    advance && emit && result.last
    |=> (phase == PH_IDLE) || (phase == PH_TRAIL))
    else $error("last item did not close the frame");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  a_length_not_query: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LENGTH) |-> (frame_type != MSG_QUERY))
    else $error("query frame reached the length field");

endmodule

/* rtl/core/mfp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfp_out_stage import mfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  result_t  result,
  output logic     out_free,
  mfp_out_if.source out_stream
);

  logic    out_valid;
  result_t held;

  assign out_free = !out_valid || out_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign out_stream.valid          = out_valid;
  assign out_stream.out_kind       = held.out_kind;
  assign out_stream.msg_type       = held.msg_type;
  assign out_stream.column         = held.column;
  assign out_stream.encryption     = held.encryption;
  assign out_stream.payload_length = held.payload_length;
  assign out_stream.data_byte      = held.data_byte;
  assign out_stream.last           = held.last;
  assign out_stream.error_code     = held.error_code;

endmodule

/* rtl/core/message_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message frame parser
// Byte-serial parser of query, response and update frames.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, unless it has a result and the
// output is occupied; each gives at most one result item: a header, a payload
// byte or an error. An accepted byte passes the input register, then the result
// register. The byte rate rests on the combinational frame update, whose longest
// path is the times-ten column accumulate with saturation. A byte that gives no
// result advances even while a result waits downstream.
module message_frame_parser import mfp_pkg::*; #(
  parameter int unsigned MAX_DIGITS  = 20,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic      clk,
  input  logic      rst,
  mfp_in_if.sink    in_stream,
  mfp_out_if.source out_stream
);

  logic     item_valid;
  in_item_t item;
  logic     emit;
  result_t  result;
  logic     out_free;
  logic     advance;

  // hold the byte only when it has a result and the output is occupied
  assign advance = item_valid && (!emit || out_free);

  mfp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mfp_step #(
    .MAX_DIGITS  (MAX_DIGITS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .emit    (emit),
    .result  (result)
  );

  mfp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && emit),
    .result     (result),
    .out_free   (out_free),
    .out_stream (out_stream)
  );

endmodule
